// ----- hw/rtl/bptc_pkg.sv -----
// ============================================================================
// bptc_pkg - shared types for the barometric compensation pipeline
// Calibration register indexes, coefficient bundle and stage records.
// ============================================================================
package bptc_pkg;

    // calibration register indexes
    localparam logic [2:0] CAL_T1_T2 = 3'd0;
    localparam logic [2:0] CAL_T3_P1 = 3'd1;
    localparam logic [2:0] CAL_P2_P3 = 3'd2;
    localparam logic [2:0] CAL_P4_P5 = 3'd3;
    localparam logic [2:0] CAL_P6_P7 = 3'd4;
    localparam logic [2:0] CAL_P8_P9 = 3'd5;
    localparam int unsigned CAL_NUM  = 6;

    localparam int unsigned DIV_BITS = 64;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } coef_t;

    // record handed from cell to cell along the divider
    typedef struct packed {
        logic        v;
        logic [31:0] tf;
        logic [31:0] tc;
        logic        ok;
        logic        neg;
        logic [63:0] d;
        logic [63:0] r;
        logic [63:0] q;
    } div_t;

    typedef struct packed {
        logic        v;
        logic [31:0] tf;
        logic [31:0] tc;
        logic [31:0] pq;
        logic        ok;
    } res_t;

endpackage

// ----- hw/rtl/bptc_front.sv -----
// ============================================================================
// bptc_front - temperature path and pressure dividend/divisor preparation
// Nine registered stages; ends with sign split into magnitudes for the divider.
// ============================================================================
module bptc_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [19:0]     raw_t,
    input  logic [19:0]     raw_p,
    input  bptc_pkg::coef_t coef,
    output bptc_pkg::div_t  div_out
);
    import bptc_pkg::*;

    logic [8:0] v_reg;

    // stage 1
    logic signed [18:0] ta, td;
    logic signed [34:0] m_ta;
    logic signed [35:0] m_td;
    logic signed [31:0] s1_tv1_reg, s1_tdd_reg;
    logic [19:0]        s1_ap_reg;
    // stage 2
    logic signed [47:0] m_t3;
    logic signed [31:0] tv2;
    logic signed [31:0] s2_tf_reg;
    logic [19:0]        s2_ap_reg;
    // stage 3
    logic signed [31:0] tc5;
    logic signed [31:0] s3_tf_reg, s3_tc_reg;
    logic signed [32:0] s3_x_reg;
    logic [19:0]        s3_ap_reg;
    // stage 4
    logic signed [65:0] m_xx;
    logic [63:0]        s4_xx_reg;
    logic signed [48:0] s4_xp5_reg, s4_xp2_reg;
    logic [31:0]        s4_tf_reg, s4_tc_reg;
    logic [19:0]        s4_ap_reg;
    // stage 5
    logic signed [79:0] m_p6, m_p3;
    logic [63:0]        s5_xxp6_reg, s5_xxp3_reg;
    logic signed [48:0] s5_xp5_reg, s5_xp2_reg;
    logic [31:0]        s5_tf_reg, s5_tc_reg;
    logic [19:0]        s5_ap_reg;
    // stage 6
    logic [63:0]        b_next, a2_next;
    logic [63:0]        s6_b_reg, s6_a2_reg;
    logic [31:0]        s6_tf_reg, s6_tc_reg;
    logic [19:0]        s6_ap_reg;
    // stage 7
    logic [79:0]        m_p1;
    logic [20:0]        pdiff;
    logic [63:0]        s7_ap1_reg, s7_num_reg;
    logic [31:0]        s7_tf_reg, s7_tc_reg;
    // stage 8
    logic [63:0]        s8_a_reg, s8_n_reg;
    logic [31:0]        s8_tf_reg, s8_tc_reg;
    // stage 9
    logic [63:0]        s9_d_reg, s9_q_reg;
    logic               s9_ok_reg, s9_neg_reg;
    logic [31:0]        s9_tf_reg, s9_tc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[7:0], in_valid};
        end
    end

    always_comb begin
        ta   = $signed({2'b00, raw_t[19:3]}) - $signed({2'b00, coef.t1, 1'b0});
        td   = $signed({3'b000, raw_t[19:4]}) - $signed({3'b000, coef.t1});
        m_ta = ta * $signed(coef.t2);
        m_td = td * td;
        m_t3 = s1_tdd_reg * $signed(coef.t3);
        tv2  = $signed(m_t3[31:0]) >>> 14;
        tc5  = (s2_tf_reg <<< 2) + s2_tf_reg + 32'sd128;
        m_xx = s3_x_reg * s3_x_reg;
        m_p6 = $signed(s4_xx_reg) * $signed(coef.p6);
        m_p3 = $signed(s4_xx_reg) * $signed(coef.p3);
        b_next  = s5_xxp6_reg
                + ({{15{s5_xp5_reg[48]}}, s5_xp5_reg} << 17)
                + ({{48{coef.p4[15]}}, coef.p4} << 35);
        a2_next = 64'h0000_8000_0000_0000
                + 64'($signed(s5_xxp3_reg) >>> 8)
                + ({{15{s5_xp2_reg[48]}}, s5_xp2_reg} << 12);
        m_p1  = s6_a2_reg * coef.p1;
        pdiff = 21'h10_0000 - {1'b0, s6_ap_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_tv1_reg  <= $signed(m_ta[31:0]) >>> 11;
            s1_tdd_reg  <= $signed(m_td[31:0]) >>> 12;
            s1_ap_reg   <= raw_p;

            s2_tf_reg   <= s1_tv1_reg + tv2;
            s2_ap_reg   <= s1_ap_reg;

            s3_tf_reg   <= s2_tf_reg;
            s3_tc_reg   <= tc5 >>> 8;
            s3_x_reg    <= $signed({s2_tf_reg[31], s2_tf_reg}) - 33'sd128000;
            s3_ap_reg   <= s2_ap_reg;

            s4_xx_reg   <= m_xx[63:0];
            s4_xp5_reg  <= s3_x_reg * $signed(coef.p5);
            s4_xp2_reg  <= s3_x_reg * $signed(coef.p2);
            s4_tf_reg   <= s3_tf_reg;
            s4_tc_reg   <= s3_tc_reg;
            s4_ap_reg   <= s3_ap_reg;

            s5_xxp6_reg <= m_p6[63:0];
            s5_xxp3_reg <= m_p3[63:0];
            s5_xp5_reg  <= s4_xp5_reg;
            s5_xp2_reg  <= s4_xp2_reg;
            s5_tf_reg   <= s4_tf_reg;
            s5_tc_reg   <= s4_tc_reg;
            s5_ap_reg   <= s4_ap_reg;

            s6_b_reg    <= b_next;
            s6_a2_reg   <= a2_next;
            s6_tf_reg   <= s5_tf_reg;
            s6_tc_reg   <= s5_tc_reg;
            s6_ap_reg   <= s5_ap_reg;

            s7_ap1_reg  <= m_p1[63:0];
            s7_num_reg  <= ({43'd0, pdiff} << 31) - s6_b_reg;
            s7_tf_reg   <= s6_tf_reg;
            s7_tc_reg   <= s6_tc_reg;

            s8_a_reg    <= 64'($signed(s7_ap1_reg) >>> 33);
            s8_n_reg    <= s7_num_reg * 64'd3125;
            s8_tf_reg   <= s7_tf_reg;
            s8_tc_reg   <= s7_tc_reg;

            s9_ok_reg   <= (s8_a_reg != 64'd0);
            s9_neg_reg  <= s8_n_reg[63] ^ s8_a_reg[63];
            s9_q_reg    <= s8_n_reg[63] ? (64'd0 - s8_n_reg) : s8_n_reg;
            s9_d_reg    <= s8_a_reg[63] ? (64'd0 - s8_a_reg) : s8_a_reg;
            s9_tf_reg   <= s8_tf_reg;
            s9_tc_reg   <= s8_tc_reg;
        end
    end

    always_comb begin
        div_out.v   = v_reg[8];
        div_out.tf  = s9_tf_reg;
        div_out.tc  = s9_tc_reg;
        div_out.ok  = s9_ok_reg;
        div_out.neg = s9_neg_reg;
        div_out.d   = s9_d_reg;
        div_out.r   = '0;
        div_out.q   = s9_q_reg;
    end

endmodule

// ----- hw/rtl/bptc_div_cell.sv -----
// ============================================================================
// bptc_div_cell - one restoring division step
// Shifts one dividend bit into the remainder and settles one quotient bit.
// ============================================================================
module bptc_div_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  bptc_pkg::div_t d_in,
    output bptc_pkg::div_t d_out
);
    import bptc_pkg::*;

    logic        v_reg;
    div_t        pay_reg;
    div_t        pay_next;
    logic [64:0] rsh;
    logic [64:0] diff;
    logic        ge;

    always_comb begin
        rsh        = {d_in.r, d_in.q[63]};
        diff       = rsh - {1'b0, d_in.d};
        ge         = !diff[64];
        pay_next   = d_in;
        pay_next.r = ge ? diff[63:0] : rsh[63:0];
        pay_next.q = {d_in.q[62:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= d_in.v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay_reg <= pay_next;
        end
    end

    always_comb begin
        d_out   = pay_reg;
        d_out.v = v_reg;
    end

endmodule

// ----- hw/rtl/bptc_back.sv -----
// ============================================================================
// bptc_back - pressure correction after the divider
// Sign restore, second-order correction terms, offset and saturation.
// ============================================================================
module bptc_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  bptc_pkg::coef_t coef,
    input  bptc_pkg::div_t  div_in,
    output bptc_pkg::res_t  res_out
);
    import bptc_pkg::*;

    // low 64 bits of a 64x64 product from three 32x32 partial products
    function automatic logic [63:0] mul_lo64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ll;
        logic [31:0] mid;
        ll  = {32'd0, a[31:0]} * {32'd0, b[31:0]};
        mid = a[31:0] * b[63:32] + a[63:32] * b[31:0];
        return ll + {mid, 32'd0};
    endfunction

    logic [4:0] v_reg;

    logic [63:0] b1_p_reg;
    logic [31:0] b1_tf_reg, b1_tc_reg;
    logic        b1_ok_reg;

    logic [63:0] s13;
    logic signed [79:0] m_p8;
    logic [63:0] b2_ss_reg, b2_p8p_reg, b2_p_reg;
    logic [31:0] b2_tf_reg, b2_tc_reg;
    logic        b2_ok_reg;

    logic signed [79:0] m_p9;
    logic [63:0] b3_p9ss_reg, b3_b8_reg, b3_p_reg;
    logic [31:0] b3_tf_reg, b3_tc_reg;
    logic        b3_ok_reg;

    logic [63:0] b4_sum_reg;
    logic [31:0] b4_tf_reg, b4_tc_reg;
    logic        b4_ok_reg;

    logic [63:0] r;
    logic [31:0] pq;
    logic [31:0] b5_pq_reg, b5_tf_reg, b5_tc_reg;
    logic        b5_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], div_in.v};
        end
    end

    always_comb begin
        s13  = 64'($signed(b1_p_reg) >>> 13);
        m_p8 = $signed(b1_p_reg) * $signed(coef.p8);
        m_p9 = $signed(b2_ss_reg) * $signed(coef.p9);
        r    = 64'($signed(b4_sum_reg) >>> 8) + ({{48{coef.p7[15]}}, coef.p7} << 4);
        if (!b4_ok_reg || r[63]) begin
            pq = 32'd0;
        end else if (|r[62:32]) begin
            pq = 32'hFFFF_FFFF;
        end else begin
            pq = r[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_p_reg    <= div_in.neg ? (64'd0 - div_in.q) : div_in.q;
            b1_tf_reg   <= div_in.tf;
            b1_tc_reg   <= div_in.tc;
            b1_ok_reg   <= div_in.ok;

            b2_ss_reg   <= mul_lo64(s13, s13);
            b2_p8p_reg  <= m_p8[63:0];
            b2_p_reg    <= b1_p_reg;
            b2_tf_reg   <= b1_tf_reg;
            b2_tc_reg   <= b1_tc_reg;
            b2_ok_reg   <= b1_ok_reg;

            b3_p9ss_reg <= m_p9[63:0];
            b3_b8_reg   <= 64'($signed(b2_p8p_reg) >>> 19);
            b3_p_reg    <= b2_p_reg;
            b3_tf_reg   <= b2_tf_reg;
            b3_tc_reg   <= b2_tc_reg;
            b3_ok_reg   <= b2_ok_reg;

            b4_sum_reg  <= b3_p_reg + 64'($signed(b3_p9ss_reg) >>> 25) + b3_b8_reg;
            b4_tf_reg   <= b3_tf_reg;
            b4_tc_reg   <= b3_tc_reg;
            b4_ok_reg   <= b3_ok_reg;

            b5_pq_reg   <= pq;
            b5_tf_reg   <= b4_tf_reg;
            b5_tc_reg   <= b4_tc_reg;
            b5_ok_reg   <= b4_ok_reg;
        end
    end

    always_comb begin
        res_out.v  = v_reg[4];
        res_out.tf = b5_tf_reg;
        res_out.tc = b5_tc_reg;
        res_out.pq = b5_pq_reg;
        res_out.ok = b5_ok_reg;
    end

endmodule

// ----- hw/rtl/baro_pressure_temp_compensation.sv -----
// ============================================================================
// baro_pressure_temp_compensation - integer barometric compensation
// Raw temperature/pressure pairs in, compensated temperature and Q24.8
// pressure out, through a pipeline with a 64-cell divider.
// ============================================================================
// Path: request accept, 9 front stages, 64 divider cells, 5 back stages,
//   then the output register that drives m_tvalid.
// Throughput: one request per cycle while the skid entry is empty; the divider
//   chain settles one quotient bit per cell, so the 64 cells set the depth, not the rate.
// Reset: synchronous, active low; clears the pipeline valid bits, the output
//   and skid valid flags and all six calibration registers (to zero).
module baro_pressure_temp_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    // input request
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [19:0] raw_temperature, [39:20] raw_pressure
    // result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,    // [31:0] fine_temperature, [63:32] temp_centideg,
                                    // [95:64] pressure_q24_8
    output logic [0:0]  m_tuser,    // [0] result_valid
    // calibration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import bptc_pkg::*;

    logic [31:0] cal_reg [CAL_NUM];
    coef_t       coef;

    div_t        chain [DIV_BITS+1];
    res_t        res;
    logic        en;

    // output register plus one skid entry
    logic        out_v_reg;
    res_t        out_reg;
    logic        skid_v_reg;
    res_t        skid_reg;

    // ---------------------------------------------------------------- config
    // Writes land any time; indexes past the last register are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CAL_NUM; i++) begin
                cal_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready && (32'(cfg_index) < CAL_NUM)) begin
            cal_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb begin
        coef.t1 = cal_reg[CAL_T1_T2][15:0];
        coef.t2 = cal_reg[CAL_T1_T2][31:16];
        coef.t3 = cal_reg[CAL_T3_P1][15:0];
        coef.p1 = cal_reg[CAL_T3_P1][31:16];
        coef.p2 = cal_reg[CAL_P2_P3][15:0];
        coef.p3 = cal_reg[CAL_P2_P3][31:16];
        coef.p4 = cal_reg[CAL_P4_P5][15:0];
        coef.p5 = cal_reg[CAL_P4_P5][31:16];
        coef.p6 = cal_reg[CAL_P6_P7][15:0];
        coef.p7 = cal_reg[CAL_P6_P7][31:16];
        coef.p8 = cal_reg[CAL_P8_P9][15:0];
        coef.p9 = cal_reg[CAL_P8_P9][31:16];
    end

    // ---------------------------------------------------------------- pipeline
    // Whole pipeline moves together; it only halts once the skid entry is
    // taken, so a result waiting at the output does not stop intake.
    assign en       = !skid_v_reg;
    assign s_tready = en;

    bptc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid && s_tready),
        .raw_t    (s_tdata[19:0]),
        .raw_p    (s_tdata[39:20]),
        .coef     (coef),
        .div_out  (chain[0])
    );

    // one cell per quotient bit, MSB first
    for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
        bptc_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .d_in    (chain[g]),
            .d_out   (chain[g+1])
        );
    end

    bptc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .coef    (coef),
        .div_in  (chain[DIV_BITS]),
        .res_out (res)
    );

    // ---------------------------------------------------------------- output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (m_tready) begin
                skid_v_reg <= 1'b0;
            end
        end else if (res.v) begin
            if (out_v_reg && !m_tready) begin
                skid_v_reg <= 1'b1;
            end else begin
                out_v_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (m_tready) begin
                out_reg <= skid_reg;
            end
        end else if (res.v) begin
            if (out_v_reg && !m_tready) begin
                skid_reg <= res;
            end else begin
                out_reg <= res;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_reg.pq, out_reg.tc, out_reg.tf};
    assign m_tuser  = out_reg.ok;

    // ---------------------------------------------------------------- checks
    // skid is only ever filled behind a held output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry held without an output result");

    // a zero divisor must not leak a pressure value
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[95:64] == 32'd0))
        else $error("pressure nonzero on invalid result");

    // intake stops only after the output was stalled
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("s_tready dropped without output stall");

endmodule

// ----- tb/baro_pressure_temp_compensation_test.sv -----
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_test - compensation pipeline testbench
// Drives raw temperature/pressure requests under several idling phases and
// calibration settings; a scoreboard predicts each result and compares it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_test;
    import bptc_pkg::*;

    typedef struct {
        logic [31:0] fine;
        logic [31:0] centi;
        logic [31:0] press;
        logic        ok;
    } comp_res_t;

    // prediction of the compensation and queue of pending results
    class comp_scoreboard;
        logic [31:0] cal [CAL_NUM];
        comp_res_t   pending [$];
        int          errors;

        // calibration starts at its reset value
        function new();
            foreach (cal[i]) cal[i] = '0;
            errors = 0;
        endfunction

        function void write_cal(logic [2:0] idx, logic [31:0] val);
            if (idx < CAL_NUM) cal[idx] = val;
        endfunction

        function comp_res_t compensate(logic [19:0] rt, logic [19:0] rp);
            comp_res_t r;
            logic signed [31:0] t1, t2, t3, ta, tv1, td, tv2, tf;
            logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
            logic signed [63:0] x, b, a, p, num, q, an, ad;
            t1 = {16'd0, cal[CAL_T1_T2][15:0]};
            t2 = {{16{cal[CAL_T1_T2][31]}}, cal[CAL_T1_T2][31:16]};
            t3 = {{16{cal[CAL_T3_P1][15]}}, cal[CAL_T3_P1][15:0]};
            p1 = {48'd0, cal[CAL_T3_P1][31:16]};
            p2 = {{48{cal[CAL_P2_P3][15]}}, cal[CAL_P2_P3][15:0]};
            p3 = {{48{cal[CAL_P2_P3][31]}}, cal[CAL_P2_P3][31:16]};
            p4 = {{48{cal[CAL_P4_P5][15]}}, cal[CAL_P4_P5][15:0]};
            p5 = {{48{cal[CAL_P4_P5][31]}}, cal[CAL_P4_P5][31:16]};
            p6 = {{48{cal[CAL_P6_P7][15]}}, cal[CAL_P6_P7][15:0]};
            p7 = {{48{cal[CAL_P6_P7][31]}}, cal[CAL_P6_P7][31:16]};
            p8 = {{48{cal[CAL_P8_P9][15]}}, cal[CAL_P8_P9][15:0]};
            p9 = {{48{cal[CAL_P8_P9][31]}}, cal[CAL_P8_P9][31:16]};
            // temperature path, 32-bit wrap
            ta = $signed({15'd0, rt[19:3]}) - (t1 <<< 1);
            tv1 = (ta * t2) >>> 11;
            td = $signed({16'd0, rt[19:4]}) - t1;
            tv2 = (((td * td) >>> 12) * t3) >>> 14;
            tf = tv1 + tv2;
            r.fine = tf;
            r.centi = (tf * 32'sd5 + 32'sd128) >>> 8;
            // pressure path, 64-bit wrap
            x = 64'(tf) - 64'sd128000;
            b = x * x * p6;
            b = b + ((x * p5) <<< 17);
            b = b + (p4 <<< 35);
            a = ((x * x * p3) >>> 8) + ((x * p2) <<< 12);
            a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
            r.ok = (a != 0);
            r.press = '0;
            if (r.ok) begin
                p = 64'sd1048576 - $signed({44'd0, rp});
                num = ((p <<< 31) - b) * 64'sd3125;
                // truncating division on magnitudes; min/-1 wraps
                an = num[63] ? -num : num;
                ad = a[63] ? -a : a;
                q = $signed($unsigned(an) / $unsigned(ad));
                p = (num[63] != a[63]) ? -q : q;
                a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
                b = (p8 * p) >>> 19;
                p = ((p + a + b) >>> 8) + (p7 <<< 4);
                if (p[63]) r.press = '0;
                else if (p[63:32] != 0) r.press = 32'hFFFF_FFFF;
                else r.press = p[31:0];
            end
            return r;
        endfunction

        function void note_request(logic [39:0] d);
            pending.push_back(compensate(d[19:0], d[39:20]));
        endfunction

        function void check_result(logic [95:0] d, logic ok);
            comp_res_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h/%b", d, ok);
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.fine || d[63:32] !== e.centi || d[95:64] !== e.press
                    || ok !== e.ok) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp %h %h %h %b got %h %h %h %b",
                             e.fine, e.centi, e.press, e.ok,
                             d[31:0], d[63:32], d[95:64], ok);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int send_idle_pct  = 0;   // chance of a sender gap
    int recv_stall_pct = 0;   // chance of a receiver stall

    comp_scoreboard sb = new();

    baro_pressure_temp_compensation DUT (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // receiver: random back-pressure, check on every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one write, then valid is dropped again before the task returns
    task automatic write_cal(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_cal(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // one request; valid stays high back to back unless a gap is drawn
    task automatic send_request(logic [19:0] rt, logic [19:0] rp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rp, rt};
        do @(posedge aclk); while (!s_tready);
        sb.note_request({rp, rt});
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (90) @(posedge aclk);
    endtask

    // typical calibration words, near-real values
    task automatic load_typical;
        write_cal(CAL_T1_T2, {16'd26435, 16'd27504});
        write_cal(CAL_T3_P1, {16'd36477, 16'hFC18});
        write_cal(CAL_P2_P3, {16'd3024, 16'hD4BC});
        write_cal(CAL_P4_P5, {16'h008C, 16'd2855});
        write_cal(CAL_P6_P7, {16'd15500, 16'hFFF9});
        write_cal(CAL_P8_P9, {16'd6000, 16'hC0B8});
    endtask

    task automatic load_random;
        for (int i = 0; i < CAL_NUM; i++) write_cal(3'(i), $urandom());
    endtask

    task automatic random_burst(int n);
        logic [19:0] rt, rp;
        for (int i = 0; i < n; i++) begin
            rt = 20'($urandom());
            rp = 20'($urandom());
            // keep most samples in the sensor's working range
            if ($urandom_range(3) != 0) begin
                rt = 20'($urandom_range(560000, 460000));
                rp = 20'($urandom_range(450000, 250000));
            end
            send_request(rt, rp);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset calibration: all coefficients zero, so divisor is zero
        send_request(20'd0, 20'd0);
        send_request(20'hFFFFF, 20'hFFFFF);
        drain();

        // typical calibration, field extremes and normal readings
        load_typical();
        send_request(20'd0, 20'd0);
        send_request(20'hFFFFF, 20'hFFFFF);
        send_request(20'd0, 20'hFFFFF);
        send_request(20'hFFFFF, 20'd0);
        send_request(20'd519888, 20'd415148);
        send_request(20'h55555, 20'hAAAAA);
        send_request(20'hAAAAA, 20'h55555);
        drain();

        // all-ones calibration words: extreme coefficients and wrapping
        for (int i = 0; i < CAL_NUM; i++) write_cal(3'(i), 32'hFFFF_FFFF);
        send_request(20'd0, 20'd0);
        send_request(20'hFFFFF, 20'hFFFFF);
        drain();
        // out-of-range index must be ignored
        write_cal(3'd6, 32'h1234_5678);
        write_cal(3'd7, 32'h0);
        send_request(20'h80000, 20'h80000);
        drain();

        // large-magnitude coefficients: pressure saturation and clamping
        write_cal(CAL_T1_T2, 32'h7FFF_0000);
        write_cal(CAL_T3_P1, 32'hFFFF_7FFF);
        write_cal(CAL_P2_P3, 32'h8000_8000);
        write_cal(CAL_P4_P5, 32'h7FFF_8000);
        write_cal(CAL_P6_P7, 32'h7FFF_8000);
        write_cal(CAL_P8_P9, 32'h8000_7FFF);
        send_request(20'd0, 20'd0);
        send_request(20'hFFFFF, 20'hFFFFF);
        send_request(20'h12345, 20'h00001);
        drain();

        // random phases: four idling mixes, typical and random calibration in turn
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            if (ph % 2 == 0) load_typical();
            else load_random();
            random_burst(190);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("baro_pressure_temp_compensation_test passed");
        else
            $display("baro_pressure_temp_compensation_test failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("baro_pressure_temp_compensation_test failed");
        $finish;
    end

endmodule
